/* src/rar_pkg.sv */
// rar_pkg: shared types and constants of the rational arithmetic block.
// Depends on nothing; used by rational_arith_reduce.

package rar_pkg;

    // Operation selector carried on the input tuser
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // Sequencer states, one-hot
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_COMB = 8'b0000_0100,
        S_ABS  = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_DIVN = 8'b0010_0000,
        S_DIVD = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    localparam int OP_W       = 2;
    localparam int RES_NUM_W  = 33;
    localparam int RES_DEN_W  = 32;
    localparam int OUT_DATA_W = 72;   // 65 result bits padded to whole bytes

endpackage

/* src/rational_arith_reduce.sv */
// rational_arith_reduce: add, subtract, multiply or divide two signed fractions and
// reduce the result. Depends on rar_pkg (types and constants).

// One beat in carries an operation and two fractions a_num/a_den and b_num/b_den; one
// beat out carries the reduced result res_num/res_den plus zero_den_error. The block
// handles one item at a time: s_axis_tready is high only while the sequencer is idle,
// and the finished result sits in an output register so the next beat can be taken
// while it waits downstream. Cross products come from one OPERAND_WIDTH x
// OPERAND_WIDTH signed multiplier, used in turn for the three products. The result is
// then reduced with a binary gcd (one compare/subtract step, one swap or one shift per
// cycle) followed by two restoring divisions of one quotient bit per cycle, all on a
// single shared subtractor. Common factors of two are stripped from numerator and
// denominator while the gcd runs, so the divisions only divide by the odd part of the
// gcd. Working values are NW = min(2*OPERAND_WIDTH+1, 64) bits wide. The next
// beat can be taken once the result is in the output register. An item with a zero
// denominator skips the reduction and goes straight to the output register.
// A zero operand denominator, or a zero divisor numerator in a divide, gives
// res_num = 0, res_den = 0 and zero_den_error = 1. Signs stay as computed: the gcd is
// taken positive, so a negative denominator is not normalized. Arithmetic wraps at 64
// bits for the widest operands; outputs are sign-extended or truncated to their
// fields. There is no configuration and no state carried between items.

module rational_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // slave side
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata, low bit up: a_num, a_den, b_num, b_den, zero pad to bytes
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // tuser: operation
    input  logic [rar_pkg::OP_W-1:0]               s_axis_tuser,
    // master side
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // tdata, low bit up: res_num (33), res_den (32), zero pad (7)
    output logic [rar_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // tuser: zero_den_error
    output logic [0:0]                             m_axis_tuser
);

    localparam int W   = OPERAND_WIDTH;
    localparam int DW  = 2 * W;                             // product width
    localparam int NW  = (2 * W + 1 > 64) ? 64 : 2 * W + 1; // numerator width, wraps at 64
    localparam int CW  = $clog2(NW);                        // division bit counter
    localparam int RNW = rar_pkg::RES_NUM_W;
    localparam int RDW = rar_pkg::RES_DEN_W;
    localparam int PAD = rar_pkg::OUT_DATA_W - RNW - RDW;

    // ---------------------------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------------------------
    rar_pkg::state_t        state_reg, state_next;
    logic [1:0]             mstep_reg, mstep_next;
    logic                   m_valid_reg, m_valid_next;

    rar_pkg::op_t           op_reg, op_next;
    logic signed [W-1:0]    an_reg, an_next;
    logic signed [W-1:0]    ad_reg, ad_next;
    logic signed [W-1:0]    bn_reg, bn_next;
    logic signed [W-1:0]    bd_reg, bd_next;
    logic signed [DW-1:0]   p1_reg, p1_next;        // first numerator product
    logic signed [DW-1:0]   p2_reg, p2_next;        // second numerator product
    logic signed [DW-1:0]   p3_reg, p3_next;        // denominator product
    logic signed [NW-1:0]   num_reg, num_next;      // combined numerator
    logic                   nneg_reg, nneg_next;
    logic                   dneg_reg, dneg_next;
    logic                   err_reg, err_next;
    logic [NW-1:0]          ga_reg, ga_next;        // gcd working pair
    logic [NW-1:0]          gb_reg, gb_next;        // ends as odd part of gcd
    logic [NW-1:0]          nm_reg, nm_next;        // |num|, later its quotient
    logic [NW-1:0]          dm_reg, dm_next;        // |den|
    logic [NW-1:0]          rem_reg, rem_next;
    logic [NW-1:0]          quo_reg, quo_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [RNW-1:0]         m_num_reg, m_num_next;
    logic [RDW-1:0]         m_den_reg, m_den_next;
    logic                   m_err_reg, m_err_next;

    // ---------------------------------------------------------------------------------
    // Shared multiplier: operand pair picked by the multiply step
    // ---------------------------------------------------------------------------------
    logic signed [W-1:0]    mul_a, mul_b;
    logic signed [DW-1:0]   prod;

    always_comb
    begin
        unique case (mstep_reg)
            2'd0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == rar_pkg::OP_MUL) ? bn_reg : bd_reg;
            end
            2'd1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == rar_pkg::OP_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // ---------------------------------------------------------------------------------
    // Shared subtractor: gcd compare/subtract or one restoring division step
    // ---------------------------------------------------------------------------------
    logic [NW:0]            sub_a, sub_b;
    logic [NW+1:0]          diff;
    logic                   ge;

    always_comb
    begin
        if (state_reg == rar_pkg::S_GCD)
        begin
            sub_a = {1'b0, ga_reg};
        end
        else
        begin
            sub_a = {rem_reg, quo_reg[NW-1]};
        end
        sub_b = {1'b0, gb_reg};
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[NW+1];

    // ---------------------------------------------------------------------------------
    // Datapath helpers
    // ---------------------------------------------------------------------------------
    logic signed [NW-1:0]   p1_ext, p2_ext;
    logic [DW-1:0]          den_mag;
    logic [NW-1:0]          num_signed;
    logic [DW-1:0]          den_signed;
    logic                   in_beat;
    logic                   out_free;
    logic                   div_last;

    assign p1_ext     = NW'(p1_reg);
    assign p2_ext     = NW'(p2_reg);
    assign den_mag    = p3_reg[DW-1] ? DW'(-p3_reg) : DW'(p3_reg);
    assign num_signed = nneg_reg ? (-nm_reg) : nm_reg;
    assign den_signed = dneg_reg ? (-quo_reg[DW-1:0]) : quo_reg[DW-1:0];
    assign in_beat    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign div_last   = (cnt_reg == CW'(NW - 1));

    // ---------------------------------------------------------------------------------
    // Sequencer and next-state logic
    // ---------------------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        mstep_next   = mstep_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        p3_next      = p3_reg;
        num_next     = num_reg;
        nneg_next    = nneg_reg;
        dneg_next    = dneg_reg;
        err_next     = err_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        nm_next      = nm_reg;
        dm_next      = dm_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        m_num_next   = m_num_reg;
        m_den_next   = m_den_reg;
        m_err_next   = m_err_reg;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rar_pkg::S_IDLE:
            begin
                if (in_beat)
                begin
                    op_next    = rar_pkg::op_t'(s_axis_tuser);
                    an_next    = s_axis_tdata[W-1:0];
                    ad_next    = s_axis_tdata[2*W-1:W];
                    bn_next    = s_axis_tdata[3*W-1:2*W];
                    bd_next    = s_axis_tdata[4*W-1:3*W];
                    mstep_next = 2'd0;
                    state_next = rar_pkg::S_MUL;
                end
            end

            rar_pkg::S_MUL:
            begin
                unique case (mstep_reg)
                    2'd0:    p1_next = prod;
                    2'd1:    p2_next = prod;
                    default: p3_next = prod;
                endcase
                mstep_next = mstep_reg + 2'd1;
                if (mstep_reg == 2'd2)
                begin
                    state_next = rar_pkg::S_COMB;
                end
            end

            rar_pkg::S_COMB:
            begin
                unique case (op_reg)
                    rar_pkg::OP_ADD: num_next = p1_ext + p2_ext;
                    rar_pkg::OP_SUB: num_next = p1_ext - p2_ext;
                    default:         num_next = p1_ext;
                endcase
                dneg_next = p3_reg[DW-1];
                // zero operand denominator, or divide by a zero fraction
                if (ad_reg == '0 || bd_reg == '0 || p3_reg == '0)
                begin
                    err_next   = 1'b1;
                    state_next = rar_pkg::S_DONE;
                end
                else
                begin
                    err_next   = 1'b0;
                    state_next = rar_pkg::S_ABS;
                end
            end

            rar_pkg::S_ABS:
            begin
                nneg_next  = num_reg[NW-1];
                nm_next    = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
                ga_next    = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
                dm_next    = NW'(den_mag);
                gb_next    = NW'(den_mag);
                state_next = rar_pkg::S_GCD;
            end

            rar_pkg::S_GCD:
            begin
                priority if (ga_reg == '0)
                begin
                    rem_next   = '0;
                    quo_next   = nm_reg;
                    cnt_next   = '0;
                    state_next = rar_pkg::S_DIVN;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    // common factor of two: strip it from the result pair too
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    nm_next = nm_reg >> 1;
                    dm_next = dm_reg >> 1;
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ge)
                begin
                    ga_next = diff[NW-1:0];
                end
                else
                begin
                    ga_next = gb_reg;
                    gb_next = ga_reg;
                end
            end

            rar_pkg::S_DIVN, rar_pkg::S_DIVD:
            begin
                rem_next = ge ? diff[NW-1:0] : sub_a[NW-1:0];
                quo_next = {quo_reg[NW-2:0], ge};
                cnt_next = cnt_reg + CW'(1);
                if (div_last)
                begin
                    if (state_reg == rar_pkg::S_DIVN)
                    begin
                        nm_next    = {quo_reg[NW-2:0], ge};
                        rem_next   = '0;
                        quo_next   = dm_reg;
                        cnt_next   = '0;
                        state_next = rar_pkg::S_DIVD;
                    end
                    else
                    begin
                        state_next = rar_pkg::S_DONE;
                    end
                end
            end

            rar_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_err_next   = err_reg;
                    if (err_reg)
                    begin
                        m_num_next = '0;
                        m_den_next = '0;
                    end
                    else
                    begin
                        m_num_next = RNW'($signed(num_signed));
                        m_den_next = RDW'($signed(den_signed));
                    end
                    state_next = rar_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rar_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= rar_pkg::S_IDLE;
            mstep_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mstep_reg   <= mstep_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        an_reg    <= an_next;
        ad_reg    <= ad_next;
        bn_reg    <= bn_next;
        bd_reg    <= bd_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        num_reg   <= num_next;
        nneg_reg  <= nneg_next;
        dneg_reg  <= dneg_next;
        err_reg   <= err_next;
        ga_reg    <= ga_next;
        gb_reg    <= gb_next;
        nm_reg    <= nm_next;
        dm_reg    <= dm_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        m_num_reg <= m_num_next;
        m_den_reg <= m_den_next;
        m_err_reg <= m_err_next;
    end

    // ---------------------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------------------
    assign s_axis_tready = (state_reg == rar_pkg::S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{PAD{1'b0}}, m_den_reg, m_num_reg};
    assign m_axis_tuser  = m_err_reg;

    // ---------------------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------------------
    // an accepted beat always starts the multiply sequence
    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (state_reg == rar_pkg::S_MUL))
        else $error("accepted beat did not start the multiply sequence");

    // the gcd/divisor register never reaches zero while it is in use
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rar_pkg::S_GCD || state_reg == rar_pkg::S_DIVN ||
         state_reg == rar_pkg::S_DIVD) |-> (gb_reg != '0))
        else $error("gcd divisor register is zero");

    // an error beat carries an all-zero result
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_num_reg == '0 && m_den_reg == '0))
        else $error("error result with nonzero fraction");

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for rational_arith_reduce, with directed and random beats.
// Depends on rar_pkg and the rational_arith_reduce RTL; a scoreboard class predicts results.

// One reduced fraction as it should leave the block
typedef struct packed {
    logic [rar_pkg::RES_NUM_W-1:0] num;
    logic [rar_pkg::RES_DEN_W-1:0] den;
    logic                          err;
} reduced_t;

class fraction_scoreboard;
    reduced_t reduced_q[$];
    int       errors;

    function new();
        errors = 0;
    endfunction

    function int pending();
        return reduced_q.size();
    endfunction

    function void report(string msg);
        $display("%0t mismatch: %s", $time, msg);
        errors++;
    endfunction

    function longint unsigned magnitude(longint v);
        longint unsigned u;
        u = v;
        return (v < 0) ? -u : u;
    endfunction

    // Sign stays with the value; the divisor is always positive
    function longint signed_div(longint v, longint unsigned g);
        longint unsigned q;
        q = magnitude(v) / g;
        return (v < 0) ? longint'(-q) : longint'(q);
    endfunction

    // Works out the reduced fraction for one accepted input beat
    function void note_operands(rar_pkg::op_t op, logic signed [15:0] an,
                                logic signed [15:0] ad, logic signed [15:0] bn,
                                logic signed [15:0] bd);
        longint          a_n, a_d, b_n, b_d, num, den;
        longint unsigned x, y, t;
        reduced_t        r;
        a_n = an;
        a_d = ad;
        b_n = bn;
        b_d = bd;
        r = '0;
        if (a_d == 0 || b_d == 0)
        begin
            r.err = 1'b1;
            reduced_q.push_back(r);
            return;
        end
        case (op)
            rar_pkg::OP_ADD:
            begin
                num = a_n * b_d + b_n * a_d;
                den = a_d * b_d;
            end
            rar_pkg::OP_SUB:
            begin
                num = a_n * b_d - b_n * a_d;
                den = a_d * b_d;
            end
            rar_pkg::OP_MUL:
            begin
                num = a_n * b_n;
                den = a_d * b_d;
            end
            default:
            begin
                num = a_n * b_d;
                den = a_d * b_n;
            end
        endcase
        if (den == 0)
        begin
            r.err = 1'b1;
            reduced_q.push_back(r);
            return;
        end
        x = magnitude(num);
        y = magnitude(den);
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0)
            x = 1;
        num = signed_div(num, x);
        den = signed_div(den, x);
        r.num = num[rar_pkg::RES_NUM_W-1:0];
        r.den = den[rar_pkg::RES_DEN_W-1:0];
        reduced_q.push_back(r);
    endfunction

    function void check_result(logic [rar_pkg::OUT_DATA_W-1:0] data, logic [0:0] user);
        reduced_t want;
        if (reduced_q.size() == 0)
        begin
            report($sformatf("result beat with nothing expected, data %h", data));
            return;
        end
        want = reduced_q.pop_front();
        if (data[rar_pkg::RES_NUM_W-1:0] !== want.num)
            report($sformatf("res_num %h, want %h", data[rar_pkg::RES_NUM_W-1:0], want.num));
        if (data[rar_pkg::RES_NUM_W+rar_pkg::RES_DEN_W-1:rar_pkg::RES_NUM_W] !== want.den)
            report($sformatf("res_den %h, want %h",
                data[rar_pkg::RES_NUM_W+rar_pkg::RES_DEN_W-1:rar_pkg::RES_NUM_W], want.den));
        if (user[0] !== want.err)
            report($sformatf("zero_den_error %b, want %b", user[0], want.err));
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OPW    = 16;
    localparam int IN_W   = ((4*OPW+7)/8)*8;
    localparam int PHASES = 4;
    localparam int RAND_PER_PHASE = 338;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [IN_W-1:0]                s_axis_tdata = '0;
    logic [rar_pkg::OP_W-1:0]       s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [rar_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]                     m_axis_tuser;

    // percent chance per cycle of a gap on each side
    int              idle_pct = 0;
    int              stall_pct = 0;

    fraction_scoreboard sb = new();

    rational_arith_reduce #(.OPERAND_WIDTH(OPW)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // Receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    // Result beats are checked at the edge that accepts them
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);

    // Drives one input beat and holds it until the block takes it.
    // tvalid stays high into the next call unless that call idles first.
    task automatic send_beat(rar_pkg::op_t op, logic [OPW-1:0] an, logic [OPW-1:0] ad,
                             logic [OPW-1:0] bn, logic [OPW-1:0] bd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {bd, bn, ad, an};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_operands(op, an, ad, bn, bd);
    endtask

    // Mix of full-range, small (so that gcds are interesting) and corner values
    function automatic logic [OPW-1:0] rand_operand();
        logic [OPW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = OPW'($urandom);
            4, 5, 6:    v = OPW'($urandom_range(0, 48) - 24);
            7:
            begin
                case ($urandom_range(0, 4))
                    0:       v = {1'b1, {(OPW-1){1'b0}}};
                    1:       v = {1'b0, {(OPW-1){1'b1}}};
                    2:       v = '0;
                    3:       v = OPW'(1);
                    default: v = '1;
                endcase
            end
            8:       v = OPW'($urandom_range(1, 7)) << $urandom_range(0, OPW-4);
            default: v = OPW'($urandom_range(1, 60) * $urandom_range(1, 60));
        endcase
        if ($urandom_range(0, 1) == 1 && v != 0)
            v = -v;
        return v;
    endfunction

    // Denominators are zero only now and then so most beats get reduced
    function automatic logic [OPW-1:0] rand_denom();
        logic [OPW-1:0] v;
        if ($urandom_range(0, 99) < 3)
            return '0;
        v = rand_operand();
        return (v == 0) ? OPW'(1) : v;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rar_pkg::op_t op;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every operation, error and zero-numerator cases
        send_beat(rar_pkg::OP_ADD, 16'd1,     16'd2,     16'd1,     16'd3);
        send_beat(rar_pkg::OP_SUB, 16'd1,     16'd2,     16'd1,     16'd2);
        send_beat(rar_pkg::OP_MUL, -16'sd3,   16'd4,     16'd4,     -16'sd3);
        send_beat(rar_pkg::OP_DIV, 16'd2,     16'd3,     16'd4,     16'd9);
        send_beat(rar_pkg::OP_ADD, 16'h7fff,  16'h7fff,  16'h7fff,  16'h7fff);
        send_beat(rar_pkg::OP_MUL, 16'h8000,  16'd1,     16'h8000,  16'd1);
        send_beat(rar_pkg::OP_ADD, 16'h8000,  16'h7fff,  16'h8000,  16'h7fff);
        send_beat(rar_pkg::OP_SUB, 16'h8000,  16'd1,     16'h7fff,  16'hffff);
        send_beat(rar_pkg::OP_MUL, 16'h7fff,  16'h8000,  16'h7fff,  16'h8000);
        send_beat(rar_pkg::OP_DIV, 16'h8000,  16'h7fff,  16'h7fff,  16'h8000);
        send_beat(rar_pkg::OP_ADD, 16'd5,     16'd0,     16'd3,     16'd7);   // a_den zero
        send_beat(rar_pkg::OP_DIV, 16'd5,     16'd3,     16'd3,     16'd0);   // b_den zero
        send_beat(rar_pkg::OP_MUL, 16'd5,     16'd0,     16'd3,     16'd0);
        send_beat(rar_pkg::OP_DIV, 16'd5,     16'd3,     16'd0,     16'd7);   // divide by zero
        send_beat(rar_pkg::OP_SUB, 16'd0,     -16'sd5,   16'd0,     16'd7);   // 0 over negative
        send_beat(rar_pkg::OP_MUL, 16'd0,     16'hffff,  16'd5,     16'd1);
        send_beat(rar_pkg::OP_DIV, 16'd0,     16'd3,     16'd5,     -16'sd7);
        send_beat(rar_pkg::OP_ADD, 16'hffff,  16'hffff,  16'hffff,  16'hffff);
        send_beat(rar_pkg::OP_DIV, 16'h8000,  16'h8000,  16'h8000,  16'h8000);
        send_beat(rar_pkg::OP_SUB, 16'h7fff,  16'd1,     16'h8000,  16'd1);
        send_beat(rar_pkg::OP_ADD, 16'h8000,  16'd1,     16'h8000,  16'd1);
        send_beat(rar_pkg::OP_DIV, 16'hffff,  16'd2,     16'd1,     16'h8000);

        // random phases: none, sender gaps, receiver stalls, both
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 58;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 58;
                end
                default:
                begin
                    idle_pct  = 33;
                    stall_pct = 33;
                end
            endcase
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                op = rar_pkg::op_t'($urandom_range(0, 3));
                if ($urandom_range(0, 19) == 0)
                    send_beat(op, OPW'($urandom), OPW'($urandom),
                              OPW'($urandom), OPW'($urandom));   // raw noise
                else
                    send_beat(op, rand_operand(), rand_denom(), rand_operand(), rand_denom());
            end
            // hold off the sender until the block has emptied out
            if (ph == 1)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
